// File: hw/rtl/clock_set_menu_seven_segment_unit_defines.svh
// Assertion macros used by the checker file of the clock-setting menu.
// Stands alone; include it by its bare file name.
`ifndef CLOCK_SET_MENU_SEVEN_SEGMENT_UNIT_DEFINES_SVH
`define CLOCK_SET_MENU_SEVEN_SEGMENT_UNIT_DEFINES_SVH

// Concurrent assertion that is switched off while reset is held.
`define CSM_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds during reset.
`define CSM_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/csm_pkg.sv
// Types, codes and display helpers for the clock-setting menu.
// Has no dependencies; used by the top level and its checker.
package csm_pkg;

  // Event codes carried with each request.
  typedef enum logic [2:0] {
    MODE_TICK    = 3'd0,
    MODE_SET     = 3'd1,
    MODE_UP      = 3'd2,
    MODE_DOWN    = 3'd3,
    MODE_REFRESH = 3'd4
  } mode_e;

  // Menu steps.
  localparam logic [2:0] STEP_STANDBY = 3'd0;
  localparam logic [2:0] STEP_MINUTES = 3'd1;
  localparam logic [2:0] STEP_HOURS   = 3'd2;
  localparam logic [2:0] STEP_DATE    = 3'd3;
  localparam logic [2:0] STEP_MONTH   = 3'd4;

  // Register map.
  localparam int unsigned PADDR_W = 3;
  localparam logic        REG_TIMEOUT = 1'b0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1500;

  // Stream widths.
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned OUT_USER_W = 4;

  // Segment patterns, active low, bit 7 is the dot.
  localparam logic [7:0] SEG_BLANK = 8'hFF;
  localparam logic [7:0] SEG_DOT   = 8'h7F;

  typedef struct packed {
    logic [3:0] month;
    logic [4:0] date;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [63:0] pattern;
  } result_data_t;

  typedef struct packed {
    logic       commit;
    logic [2:0] step;
  } result_user_t;

  // Font for one decimal digit.
  function automatic logic [7:0] seg_font(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0: s = 8'hC0;
      4'd1: s = 8'hF9;
      4'd2: s = 8'hA4;
      4'd3: s = 8'hB0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hF8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // Tens digit of a value below 64, by comparison.
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    priority if (v >= 6'd60) t = 4'd6;
    else if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else t = 4'd0;
    return t;
  endfunction

  // Ones digit: the value less ten times its tens digit.
  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [5:0] t6;
    logic [5:0] r;
    t6 = {2'b00, tens_of(v)};
    r  = v - (t6 << 3) - (t6 << 1);
    return r[3:0];
  endfunction

  function automatic logic [7:0] tens_seg(input logic [5:0] v);
    return seg_font(tens_of(v));
  endfunction

  function automatic logic [7:0] ones_seg(input logic [5:0] v);
    return seg_font(ones_of(v));
  endfunction

  // Tens digit with a leading zero shown blank.
  function automatic logic [7:0] tens_blanked(input logic [5:0] v);
    return (tens_of(v) == 4'd0) ? SEG_BLANK : seg_font(tens_of(v));
  endfunction

endpackage

// File: hw/rtl/clock_set_menu_seven_segment_unit.sv
// A result is captured in the result register, or in the skid register while
// the master side stalls. Throughput: one request per cycle while the skid
// register is empty; the menu state, the next-state logic and the result
// register form a single registered stage. A result register and a skid
// register decouple the sides; slave tready depends on the skid register only.
// Reset (rst_ni, asynchronous): menu in standby, all times zero, timeout setting 1500.
module clock_set_menu_seven_segment_unit
  import csm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Event requests
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [4:0] cur_hours, [10:5] cur_minutes, [16:11] cur_seconds,
  // [21:17] cur_date, [25:22] cur_month, rest zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [2:0] mode
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,
  // Results
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [63:0] segment_pattern, [68:64] set_hours, [74:69] set_minutes,
  // [79:75] set_date, [83:80] set_month, rest zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // [2:0] menu_step, [3] commit
  output logic [OUT_USER_W-1:0] m_axis_tuser_o,
  // Configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Configuration register.
  logic [15:0] timeout_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_cfg_q <= TIMEOUT_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_TIMEOUT)) begin
      timeout_cfg_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_cfg_q} : 32'd0;

  // Request fields.
  logic       in_acc;
  mode_e      mode;
  logic [4:0] cur_hours;
  logic [5:0] cur_minutes;
  logic       cur_sec_odd;
  logic [4:0] cur_date;
  logic [3:0] cur_month;

  assign in_acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign mode        = mode_e'(s_axis_tuser_i);
  assign cur_hours   = s_axis_tdata_i[4:0];
  assign cur_minutes = s_axis_tdata_i[10:5];
  assign cur_sec_odd = s_axis_tdata_i[11];
  assign cur_date    = s_axis_tdata_i[21:17];
  assign cur_month   = s_axis_tdata_i[25:22];

  // Menu state.
  logic [4:0]  now_hours_q, now_hours_d;
  logic [5:0]  now_minutes_q, now_minutes_d;
  logic        now_sec_odd_q, now_sec_odd_d;
  logic [4:0]  now_date_q, now_date_d;
  logic [3:0]  now_month_q, now_month_d;
  logic [4:0]  edit_hours_q, edit_hours_d;
  logic [5:0]  edit_minutes_q, edit_minutes_d;
  logic [4:0]  edit_date_q, edit_date_d;
  logic [3:0]  edit_month_q, edit_month_d;
  logic [2:0]  step_q, step_d;
  logic [15:0] timeout_q, timeout_d;
  logic        commit;

  // Next-state logic for one event.
  always_comb begin
    now_hours_d    = now_hours_q;
    now_minutes_d  = now_minutes_q;
    now_sec_odd_d  = now_sec_odd_q;
    now_date_d     = now_date_q;
    now_month_d    = now_month_q;
    edit_hours_d   = edit_hours_q;
    edit_minutes_d = edit_minutes_q;
    edit_date_d    = edit_date_q;
    edit_month_d   = edit_month_q;
    step_d         = step_q;
    timeout_d      = timeout_q;
    commit         = 1'b0;
    unique case (mode)
      MODE_TICK: begin
        // Count down; reaching zero drops back to standby.
        if (timeout_q != 16'd0) begin
          timeout_d = timeout_q - 16'd1;
          if (timeout_q == 16'd1) begin
            step_d = STEP_STANDBY;
          end
        end
      end
      MODE_SET: begin
        timeout_d = timeout_cfg_q;
        if (step_q == STEP_STANDBY) begin
          edit_hours_d   = now_hours_q;
          edit_minutes_d = now_minutes_q;
          edit_date_d    = now_date_q;
          edit_month_d   = now_month_q;
        end
        if (step_q >= STEP_MONTH) begin
          step_d = STEP_STANDBY;
          commit = 1'b1;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      MODE_UP: begin
        if (step_q != STEP_STANDBY) begin
          timeout_d = timeout_cfg_q;
          unique case (step_q)
            STEP_MINUTES: edit_minutes_d = ({1'b0, edit_minutes_q} + 7'd1 > 7'd59) ?
                                           6'd0 : edit_minutes_q + 6'd1;
            STEP_HOURS:   edit_hours_d = ({1'b0, edit_hours_q} + 6'd1 > 6'd23) ?
                                         5'd0 : edit_hours_q + 5'd1;
            STEP_DATE:    edit_date_d = ({1'b0, edit_date_q} + 6'd1 > 6'd31) ?
                                        5'd1 : edit_date_q + 5'd1;
            STEP_MONTH:   edit_month_d = ({1'b0, edit_month_q} + 5'd1 > 5'd12) ?
                                         4'd1 : edit_month_q + 4'd1;
            default: ;
          endcase
        end
      end
      MODE_DOWN: begin
        if (step_q != STEP_STANDBY) begin
          timeout_d = timeout_cfg_q;
          unique case (step_q)
            STEP_MINUTES: edit_minutes_d = (edit_minutes_q == 6'd0) ?
                                           6'd59 : edit_minutes_q - 6'd1;
            STEP_HOURS:   edit_hours_d = (edit_hours_q == 5'd0) ?
                                         5'd23 : edit_hours_q - 5'd1;
            STEP_DATE:    edit_date_d = (edit_date_q <= 5'd1) ?
                                        5'd31 : edit_date_q - 5'd1;
            STEP_MONTH:   edit_month_d = (edit_month_q <= 4'd1) ?
                                         4'd12 : edit_month_q - 4'd1;
            default: ;
          endcase
        end
      end
      MODE_REFRESH: begin
        // The clock is only followed in standby.
        if (step_q == STEP_STANDBY) begin
          now_hours_d   = cur_hours;
          now_minutes_d = cur_minutes;
          now_sec_odd_d = cur_sec_odd;
          now_date_d    = cur_date;
          now_month_d   = cur_month;
        end
      end
      default: ;
    endcase
  end

  // State registers, updated only when a request is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_hours_q    <= '0;
      now_minutes_q  <= '0;
      now_sec_odd_q  <= 1'b0;
      now_date_q     <= '0;
      now_month_q    <= '0;
      edit_hours_q   <= '0;
      edit_minutes_q <= '0;
      edit_date_q    <= '0;
      edit_month_q   <= '0;
      step_q         <= STEP_STANDBY;
      timeout_q      <= '0;
    end else if (in_acc) begin
      now_hours_q    <= now_hours_d;
      now_minutes_q  <= now_minutes_d;
      now_sec_odd_q  <= now_sec_odd_d;
      now_date_q     <= now_date_d;
      now_month_q    <= now_month_d;
      edit_hours_q   <= edit_hours_d;
      edit_minutes_q <= edit_minutes_d;
      edit_date_q    <= edit_date_d;
      edit_month_q   <= edit_month_d;
      step_q         <= step_d;
      timeout_q      <= timeout_d;
    end
  end

  // Display for the state after the event.
  logic [7:0] digit [8];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      digit[i] = SEG_BLANK;
    end
    unique case (step_d)
      STEP_STANDBY: begin
        digit[7] = tens_blanked({1'b0, now_date_d});
        digit[6] = ones_seg({1'b0, now_date_d}) & SEG_DOT;
        digit[5] = tens_seg({2'b00, now_month_d});
        digit[4] = ones_seg({2'b00, now_month_d});
        digit[3] = tens_blanked({1'b0, now_hours_d});
        digit[2] = ones_seg({1'b0, now_hours_d});
        if (!now_sec_odd_d) begin
          digit[2] = digit[2] & SEG_DOT;
        end
        digit[1] = tens_seg(now_minutes_d);
        digit[0] = ones_seg(now_minutes_d);
      end
      STEP_MINUTES: begin
        digit[1] = tens_seg(edit_minutes_d);
        digit[0] = ones_seg(edit_minutes_d) & SEG_DOT;
      end
      STEP_HOURS: begin
        digit[3] = tens_seg({1'b0, edit_hours_d});
        digit[2] = ones_seg({1'b0, edit_hours_d}) & SEG_DOT;
      end
      STEP_DATE: begin
        digit[7] = tens_seg({1'b0, edit_date_d});
        digit[6] = ones_seg({1'b0, edit_date_d}) & SEG_DOT;
      end
      default: begin
        digit[5] = tens_seg({2'b00, edit_month_d});
        digit[4] = ones_seg({2'b00, edit_month_d}) & SEG_DOT;
      end
    endcase
  end

  result_data_t res_data;
  result_user_t res_user;

  always_comb begin
    res_data.pattern = {digit[7], digit[6], digit[5], digit[4],
                        digit[3], digit[2], digit[1], digit[0]};
    res_data.hours   = edit_hours_d;
    res_data.minutes = edit_minutes_d;
    res_data.date    = edit_date_d;
    res_data.month   = edit_month_d;
    res_user.step    = step_d;
    res_user.commit  = commit;
  end

  // Result register with a skid register behind it.
  logic         out_valid_q, skid_valid_q;
  result_data_t out_data_q, skid_data_q;
  result_user_t out_user_q, skid_user_q;
  logic         out_take, out_free;

  assign s_axis_tready_o = !skid_valid_q;
  assign out_take        = out_valid_q && m_axis_tready_i;
  assign out_free        = out_take || !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end else if (in_acc) begin
        out_data_q <= res_data;
        out_user_q <= res_user;
      end
    end else if (in_acc) begin
      skid_data_q <= res_data;
      skid_user_q <= res_user;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_data_q};
  assign m_axis_tuser_o  = out_user_q;

endmodule

// File: hw/rtl/csm_checker.sv
// Port-level checks for the clock-setting menu, bound to its top level.
// Depends on csm_pkg and the assertion macros header.
`include "clock_set_menu_seven_segment_unit_defines.svh"

module csm_checker
  import csm_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic [OUT_USER_W-1:0] m_axis_tuser_o
);

  // A stalled result keeps its payload.
  `CSM_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled result changed")

  // The menu step never leaves its five codes.
  `CSM_ASSERT(a_step_range, clk_i, rst_ni, m_axis_tvalid_o |-> m_axis_tuser_o[2:0] <= STEP_MONTH, "menu step out of range")

  // A commit always lands back in standby.
  `CSM_ASSERT(a_commit_standby, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[3] |-> m_axis_tuser_o[2:0] == STEP_STANDBY, "commit outside standby")

  // While minutes are edited only the two lowest digits are lit.
  `CSM_ASSERT(a_minutes_blank, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o[2:0] == STEP_MINUTES |-> m_axis_tdata_o[63:16] == '1, "digits lit outside the minutes field")

endmodule

bind clock_set_menu_seven_segment_unit csm_checker u_csm_checker (.*);
